@@ hdl/g2e_pkg.sv @@
// ----------------------------------------------------------------------------
// g2e_pkg : shared constants and types for geodetic_to_ecef
// Angle formats, WGS84 constants, pipeline stage counts and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package g2e_pkg;

    localparam int CW           = 34;
    localparam int CORDIC_STEPS = 31;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 51;
    localparam int LAT_MUL      = 2;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [63:0]   t_s64;
    typedef logic        [63:0]   t_u64;
    typedef logic        [127:0]  t_u128;

    localparam t_cw DEG_QUARTER = 34'sd754974720;
    localparam t_cw DEG_HALF    = 34'sd1509949440;
    localparam t_cw DEG_FULL    = 34'sd3019898880;
    localparam t_cw CORDIC_GAIN = 34'sd652032874;

    localparam logic [33:0] RAD_PER_DEG_Q = 34'd9595049034;
    localparam t_u64        ECC2_Q64      = 64'd123489514410299149;
    localparam logic [32:0] SEMI_MAJOR_MM = 33'd6378137000;
    localparam logic [78:0] DIV_NUM       = {SEMI_MAJOR_MM, 46'd0};

    // register counts from the input port
    localparam int LAT_COR = CORDIC_STEPS + 3;
    localparam int T_DD    = LAT_COR + LAT_MUL + 2;
    localparam int T_S     = T_DD + SQRT_STEPS + 1;
    localparam int T_NF    = T_S + DIV_STEPS;
    localparam int T_P     = T_NF + LAT_MUL + 1;
    localparam int T_T     = T_P + LAT_MUL + 2;
    localparam int T_OUT   = T_T + LAT_MUL + 2;

    function automatic t_cw atan_tab(input int i);
        unique case (i)
            0:       return 34'sd843314857;
            1:       return 34'sd497837830;
            2:       return 34'sd263043837;
            3:       return 34'sd133525159;
            4:       return 34'sd67021687;
            5:       return 34'sd33543516;
            6:       return 34'sd16775851;
            7:       return 34'sd8388437;
            8:       return 34'sd4194283;
            9:       return 34'sd2097149;
            default: return t_cw'(64'd1 << (30 - i));
        endcase
    endfunction

endpackage

@@ hdl/geodetic_to_ecef.sv @@
// ----------------------------------------------------------------------------
// geodetic_to_ecef : WGS84 geodetic point to Earth-centred Earth-fixed
// Sine and cosine by CORDIC, prime-vertical radius by a pipelined square
// root and long division, then rounded products to X, Y and Z in mm.
//
//  channel  direction  fields (lowest bit up)
//  s_axis   in         latitude 31, longitude 32, altitude 31, pad 2
//  m_axis   out        ecef_x 34, ecef_y 34, ecef_z 34, pad 2
//
// One item per cycle while the output is not stalled; the pipeline holds the 31 CORDIC
// steps, 32 square-root steps and 51 divider steps, one per stage.
// Reset clears the valid bits only; the datapath needs no reset.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module geodetic_to_ecef (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [95:0]   i_s_axis_tdata,   // latitude, longitude, altitude
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [103:0]  o_m_axis_tdata    // ecef_x, ecef_y, ecef_z
);
    import g2e_pkg::*;

    localparam int D_LAT = T_P - LAT_COR;
    localparam int D_LON = T_T - LAT_COR;
    localparam int D_ALT = T_P - 1;
    localparam int D_ZR  = T_OUT - T_T;

    logic               n_en;
    logic [T_OUT-1:0]   r_vld;
    logic signed [31:0] w_lat, w_lon;
    t_cw                w_slat, w_clat, w_slon, w_clon;

    function automatic logic [31:0] mag_cw(input t_cw v);
        return v[CW-1] ? 32'(-v) : 32'(v);
    endfunction

    function automatic t_u64 mag_64(input t_s64 v);
        return v[63] ? t_u64'(-v) : t_u64'(v);
    endfunction

    assign n_en            = !r_vld[T_OUT-1] || i_m_axis_tready;
    assign o_s_axis_tready = n_en;
    assign o_m_axis_tvalid = r_vld[T_OUT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[T_OUT-2:0], i_s_axis_tvalid};
        end
    end

    assign w_lat = 32'($signed(i_s_axis_tdata[30:0]));
    assign w_lon = $signed(i_s_axis_tdata[62:31]);

    g2e_cordic u_cor_lat (
        .i_clk(i_clk), .i_en(n_en), .i_angle(w_lat), .o_sin(w_slat), .o_cos(w_clat)
    );
    g2e_cordic u_cor_lon (
        .i_clk(i_clk), .i_en(n_en), .i_angle(w_lon), .o_sin(w_slon), .o_cos(w_clon)
    );

    // side delay lines
    t_cw                r_clat_d [D_LAT];
    t_cw                r_slat_d [D_LAT];
    t_cw                r_clon_d [D_LON];
    t_cw                r_slon_d [D_LON];
    logic signed [30:0] r_alt_d  [D_ALT];

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_clat_d[0] <= w_clat;
            r_slat_d[0] <= w_slat;
            for (int k = 1; k < D_LAT; k++) begin
                r_clat_d[k] <= r_clat_d[k-1];
                r_slat_d[k] <= r_slat_d[k-1];
            end
            r_clon_d[0] <= w_clon;
            r_slon_d[0] <= w_slon;
            for (int k = 1; k < D_LON; k++) begin
                r_clon_d[k] <= r_clon_d[k-1];
                r_slon_d[k] <= r_slon_d[k-1];
            end
            r_alt_d[0] <= $signed(i_s_axis_tdata[93:63]);
            for (int k = 1; k < D_ALT; k++) begin
                r_alt_d[k] <= r_alt_d[k-1];
            end
        end
    end

    // squares and the ellipsoid term
    t_u64  r_c2, r_s2;
    t_u64  r_c2_d [LAT_MUL];
    t_u64  r_s2_d [LAT_MUL];
    t_u128 w_se;
    t_u128 n_se_rnd;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_c2      <= 64'(mag_cw(w_clat)) * 64'(mag_cw(w_clat));
            r_s2      <= 64'(mag_cw(w_slat)) * 64'(mag_cw(w_slat));
            r_c2_d[0] <= r_c2;
            r_s2_d[0] <= r_s2;
            for (int k = 1; k < LAT_MUL; k++) begin
                r_c2_d[k] <= r_c2_d[k-1];
                r_s2_d[k] <= r_s2_d[k-1];
            end
        end
    end

    g2e_mul u_mul_e (.i_clk(i_clk), .i_en(n_en), .i_a(r_s2), .i_b(ECC2_Q64), .o_p(w_se));

    assign n_se_rnd = w_se + (128'd1 << 63);

    // square root, one result bit per stage
    logic [63:0] r_sq_v [SQRT_STEPS+1];
    logic [31:0] r_sq_q [SQRT_STEPS+1];
    logic [33:0] r_sq_r [SQRT_STEPS+1];
    logic [35:0] n_sq_r2 [SQRT_STEPS];
    logic [35:0] n_sq_t  [SQRT_STEPS];
    logic        n_sq_ge [SQRT_STEPS];

    always_comb begin
        for (int i = 0; i < SQRT_STEPS; i++) begin
            n_sq_r2[i] = {r_sq_r[i], r_sq_v[i][63:62]};
            n_sq_t[i]  = {2'b00, r_sq_q[i], 2'b01};
            n_sq_ge[i] = n_sq_r2[i] >= n_sq_t[i];
        end
    end

    logic [32:0] n_s;
    always_comb begin
        n_s = 33'(r_sq_q[SQRT_STEPS])
            + 33'(r_sq_r[SQRT_STEPS] > 34'(r_sq_q[SQRT_STEPS]));
        if (n_s == '0) begin
            n_s = 33'd1;
        end
    end

    // long division, one quotient bit per stage
    logic [32:0]          r_dv_r  [DIV_STEPS+1];
    logic [32:0]          r_dv_s  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_dv_q  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_dv_lo [DIV_STEPS+1];
    logic [33:0]          n_dv_r2 [DIV_STEPS];
    logic                 n_dv_ge [DIV_STEPS];

    always_comb begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            n_dv_r2[j] = {r_dv_r[j], r_dv_lo[j][DIV_STEPS-1]};
            n_dv_ge[j] = n_dv_r2[j] >= {1'b0, r_dv_s[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sq_v[0] <= r_c2_d[LAT_MUL-1] + r_s2_d[LAT_MUL-1] - n_se_rnd[127:64];
            r_sq_q[0] <= '0;
            r_sq_r[0] <= '0;
            for (int i = 0; i < SQRT_STEPS; i++) begin
                r_sq_r[i+1] <= n_sq_ge[i] ? 34'(n_sq_r2[i] - n_sq_t[i]) : 34'(n_sq_r2[i]);
                r_sq_q[i+1] <= {r_sq_q[i][30:0], n_sq_ge[i]};
                r_sq_v[i+1] <= {r_sq_v[i][61:0], 2'b00};
            end

            r_dv_r[0]  <= 33'(DIV_NUM[78:DIV_STEPS]);
            r_dv_lo[0] <= DIV_NUM[DIV_STEPS-1:0] | DIV_STEPS'(n_s >> 1);
            r_dv_q[0]  <= '0;
            r_dv_s[0]  <= n_s;
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dv_r[j+1]  <= n_dv_ge[j] ? 33'(n_dv_r2[j] - 34'(r_dv_s[j]))
                                           : 33'(n_dv_r2[j]);
                r_dv_q[j+1]  <= {r_dv_q[j][DIV_STEPS-2:0], n_dv_ge[j]};
                r_dv_lo[j+1] <= {r_dv_lo[j][DIV_STEPS-2:0], 1'b0};
                r_dv_s[j+1]  <= r_dv_s[j];
            end
        end
    end

    // prime-vertical radius terms and altitude sums
    logic [DIV_STEPS-1:0] r_nf_d [LAT_MUL];
    t_u128                w_ne;
    t_u128                n_ne_rnd;
    t_s64                 n_hf;
    t_s64                 r_p, r_pz;

    g2e_mul u_mul_n (
        .i_clk(i_clk), .i_en(n_en), .i_a(64'(r_dv_q[DIV_STEPS])), .i_b(ECC2_Q64), .o_p(w_ne)
    );

    assign n_ne_rnd = w_ne + (128'd1 << 63);
    assign n_hf     = t_s64'(r_alt_d[D_ALT-1]) <<< 16;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_nf_d[0] <= r_dv_q[DIV_STEPS];
            for (int k = 1; k < LAT_MUL; k++) begin
                r_nf_d[k] <= r_nf_d[k-1];
            end
            r_p  <= t_s64'(64'(r_nf_d[LAT_MUL-1])) + n_hf;
            r_pz <= t_s64'(64'(r_nf_d[LAT_MUL-1]) - n_ne_rnd[127:64]) + n_hf;
        end
    end

    // first rounded products: (N+h) cos(lat) and Z
    t_u64  r_m_p, r_m_clat, r_m_pz, r_m_slat;
    logic  r_sg_t [LAT_MUL+1];
    logic  r_sg_z [LAT_MUL+1];
    t_u128 w_pt, w_pzs, n_pt_rnd, n_pzs_rnd;
    t_s64  r_t, r_zr;
    t_s64  r_zr_d [D_ZR];

    g2e_mul u_mul_t (.i_clk(i_clk), .i_en(n_en), .i_a(r_m_p),  .i_b(r_m_clat), .o_p(w_pt));
    g2e_mul u_mul_z (.i_clk(i_clk), .i_en(n_en), .i_a(r_m_pz), .i_b(r_m_slat), .o_p(w_pzs));

    assign n_pt_rnd  = w_pt  + (128'd1 << 29);
    assign n_pzs_rnd = w_pzs + (128'd1 << 45);

    // second rounded products: X and Y
    t_u64  r_m_t, r_m_clon, r_m_slon;
    logic  r_sg_x [LAT_MUL+1];
    logic  r_sg_y [LAT_MUL+1];
    t_u128 w_px, w_py, n_px_rnd, n_py_rnd;
    t_s64  r_x, r_y;

    g2e_mul u_mul_x (.i_clk(i_clk), .i_en(n_en), .i_a(r_m_t), .i_b(r_m_clon), .o_p(w_px));
    g2e_mul u_mul_y (.i_clk(i_clk), .i_en(n_en), .i_a(r_m_t), .i_b(r_m_slon), .o_p(w_py));

    assign n_px_rnd = w_px + (128'd1 << 45);
    assign n_py_rnd = w_py + (128'd1 << 45);

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_m_p     <= mag_64(r_p);
            r_m_clat  <= 64'(mag_cw(r_clat_d[D_LAT-1]));
            r_m_pz    <= mag_64(r_pz);
            r_m_slat  <= 64'(mag_cw(r_slat_d[D_LAT-1]));
            r_sg_t[0] <= r_p[63]  ^ r_clat_d[D_LAT-1][CW-1];
            r_sg_z[0] <= r_pz[63] ^ r_slat_d[D_LAT-1][CW-1];
            for (int k = 1; k <= LAT_MUL; k++) begin
                r_sg_t[k] <= r_sg_t[k-1];
                r_sg_z[k] <= r_sg_z[k-1];
            end
            r_t  <= r_sg_t[LAT_MUL] ? -t_s64'(n_pt_rnd[93:30])  : t_s64'(n_pt_rnd[93:30]);
            r_zr <= r_sg_z[LAT_MUL] ? -t_s64'(n_pzs_rnd[109:46]) : t_s64'(n_pzs_rnd[109:46]);

            r_zr_d[0] <= r_zr;
            for (int k = 1; k < D_ZR; k++) begin
                r_zr_d[k] <= r_zr_d[k-1];
            end

            r_m_t     <= mag_64(r_t);
            r_m_clon  <= 64'(mag_cw(r_clon_d[D_LON-1]));
            r_m_slon  <= 64'(mag_cw(r_slon_d[D_LON-1]));
            r_sg_x[0] <= r_t[63] ^ r_clon_d[D_LON-1][CW-1];
            r_sg_y[0] <= r_t[63] ^ r_slon_d[D_LON-1][CW-1];
            for (int k = 1; k <= LAT_MUL; k++) begin
                r_sg_x[k] <= r_sg_x[k-1];
                r_sg_y[k] <= r_sg_y[k-1];
            end
            r_x <= r_sg_x[LAT_MUL] ? -t_s64'(n_px_rnd[109:46]) : t_s64'(n_px_rnd[109:46]);
            r_y <= r_sg_y[LAT_MUL] ? -t_s64'(n_py_rnd[109:46]) : t_s64'(n_py_rnd[109:46]);
        end
    end

    assign o_m_axis_tdata = {2'b00, r_zr_d[D_ZR-1][33:0], r_y[33:0], r_x[33:0]};

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[T_DD+SQRT_STEPS-1] |-> r_sq_r[SQRT_STEPS] <= {1'b0, r_sq_q[SQRT_STEPS], 1'b0})
        else $error("square root remainder above twice the root");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[T_NF-1] |-> r_dv_r[DIV_STEPS] < r_dv_s[DIV_STEPS])
        else $error("divider remainder not below divisor");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_en && r_vld[T_OUT-2]) |=> o_m_axis_tvalid)
        else $error("item lost on its way to the output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

@@ hdl/g2e_mul.sv @@
// ----------------------------------------------------------------------------
// g2e_mul : pipelined 64 x 64 unsigned multiplier
// Four 32 x 32 partial products in the first stage, their sum in the second.
// ----------------------------------------------------------------------------
module g2e_mul (
    input  logic            i_clk,
    input  logic            i_en,
    input  g2e_pkg::t_u64   i_a,
    input  g2e_pkg::t_u64   i_b,
    output g2e_pkg::t_u128  o_p
);
    import g2e_pkg::*;

    t_u64 r_p00, r_p01, r_p10, r_p11;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
            r_p01 <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
            r_p10 <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
            r_p11 <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
            o_p   <= 128'(r_p00) + (128'(r_p01) << 32) + (128'(r_p10) << 32)
                   + (128'(r_p11) << 64);
        end
    end

endmodule

@@ hdl/g2e_cordic.sv @@
// ----------------------------------------------------------------------------
// g2e_cordic : pipelined sine and cosine of an angle in 2^-23 degree
// Wrap and fold the angle, scale to radians at 2^-30, then one rotation
// step per stage; results at 2^-30.
// ----------------------------------------------------------------------------
module g2e_cordic (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_angle,
    output g2e_pkg::t_cw        o_sin,
    output g2e_pkg::t_cw        o_cos
);
    import g2e_pkg::*;

    t_cw         n_d0, n_d1, n_d2;
    logic        n_flip;
    logic [29:0] r_mag;
    logic        r_neg, r_flip0;
    logic [63:0] n_prod;
    logic [30:0] n_rm;

    t_cw  r_x [CORDIC_STEPS+1];
    t_cw  r_y [CORDIC_STEPS+1];
    t_cw  r_z [CORDIC_STEPS+1];
    logic r_fl [CORDIC_STEPS+1];

    always_comb begin
        n_d0 = t_cw'(i_angle);
        n_d1 = n_d0;
        if (n_d0 >= DEG_HALF) begin
            n_d1 = n_d0 - DEG_FULL;
        end
        if (n_d1 < -DEG_HALF) begin
            n_d1 = n_d1 + DEG_FULL;
        end
        n_d2   = n_d1;
        n_flip = 1'b0;
        priority if (n_d1 > DEG_QUARTER) begin
            n_d2   = n_d1 - DEG_HALF;
            n_flip = 1'b1;
        end else if (n_d1 < -DEG_QUARTER) begin
            n_d2   = n_d1 + DEG_HALF;
            n_flip = 1'b1;
        end
    end

    assign n_prod = 64'(r_mag) * 64'(RAD_PER_DEG_Q) + (64'd1 << 31);
    assign n_rm   = n_prod[62:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= n_d2[CW-1] ? 30'(-n_d2) : 30'(n_d2);
            r_neg   <= n_d2[CW-1];
            r_flip0 <= n_flip;

            r_x[0]  <= CORDIC_GAIN;
            r_y[0]  <= '0;
            r_z[0]  <= r_neg ? -t_cw'({3'b000, n_rm}) : t_cw'({3'b000, n_rm});
            r_fl[0] <= r_flip0;

            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (!r_z[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_tab(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_tab(i);
                end
                r_fl[i+1] <= r_fl[i];
            end

            o_sin <= r_fl[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
            o_cos <= r_fl[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        end
    end

endmodule

@@ test/geodetic_to_ecef_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// geodetic_to_ecef_test : self-checking bench for geodetic_to_ecef
// Streams geodetic points through the block with random gaps on both sides,
// including one long output hold-off. An integer model of the CORDIC, square
// root, division and rounded products gives the expected ECEF item, which is
// compared field by field with each item that leaves the block.
// ----------------------------------------------------------------------------
module geodetic_to_ecef_test;
    import g2e_pkg::*;

    localparam longint LAT_MAX = 64'sd754974720;
    localparam longint LON_MAX = 64'sd1509949440;
    localparam longint ALT_MAX = 64'sd1000000000;
    localparam longint FULL_TURN = 64'sd3019898880;
    localparam int WATCHDOG = 20000;
    localparam int HOLD_OFF = 400;

    typedef struct packed {
        logic signed [30:0] altitude;
        logic signed [31:0] longitude;
        logic signed [30:0] latitude;
    } t_point;

    typedef struct packed {
        logic signed [33:0] ecef_z;
        logic signed [33:0] ecef_y;
        logic signed [33:0] ecef_x;
    } t_ecef;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    t_point point_q[$];
    t_ecef  ecef_q[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     hold_count = 0;
    bit     hold_done = 0;
    bit     no_gaps = 0;
    bit     stim_done = 0;

    geodetic_to_ecef DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // round(a*b / 2^k) on magnitudes, half up
    function automatic logic [127:0] mag_mul_round(logic [63:0] a, logic [63:0] b, int k);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p + (128'd1 << (k - 1))) >> k;
    endfunction

    function automatic longint signed_mul_round(longint a, longint b, int k);
        logic [63:0] ma, mb, m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m = 64'(mag_mul_round(ma, mb, k));
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] root_round(logic [63:0] v);
        logic [63:0] res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits >>= 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v -= res + bits;
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        if (v > res) res++;
        return res;
    endfunction

    task automatic angle_sin_cos(input longint d, output longint sn, output longint cs);
        bit flip;
        longint x, y, z, nx;
        logic [63:0] rm;
        flip = 0;
        x = CORDIC_GAIN;
        y = 0;
        if (d >= LON_MAX) d -= FULL_TURN;
        if (d < -LON_MAX) d += FULL_TURN;
        if (d > LAT_MAX) begin
            d -= LON_MAX;
            flip = 1;
        end else if (d < -LAT_MAX) begin
            d += LON_MAX;
            flip = 1;
        end
        rm = ((d < 0 ? -d : d) * 64'd9595049034 + (64'd1 << 31)) >> 32;
        z = d < 0 ? -longint'(rm) : longint'(rm);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= longint'(atan_tab(i));
            end else begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += longint'(atan_tab(i));
            end
            x = nx;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    task automatic predict_ecef(input t_point pt, output t_ecef r);
        longint slat, clat, slon, clon, hf, p, pz, t;
        logic [63:0] c2, s2, dd, s, nf, nz;
        logic [127:0] num, q, rem;
        angle_sin_cos(longint'(pt.latitude), slat, clat);
        angle_sin_cos(longint'(pt.longitude), slon, clon);
        c2 = (clat < 0 ? -clat : clat) * (clat < 0 ? -clat : clat);
        s2 = (slat < 0 ? -slat : slat) * (slat < 0 ? -slat : slat);
        dd = c2 + s2 - 64'(mag_mul_round(s2, ECC2_Q64, 64));
        s = root_round(dd);
        if (s == 0) s = 1;
        num = 128'(64'd6378137000) << 30;
        q = num / s;
        rem = num % s;
        nf = 64'((q << 16) + (((rem << 16) + (s >> 1)) / s));
        nz = nf - 64'(mag_mul_round(nf, ECC2_Q64, 64));
        hf = longint'(pt.altitude) * 65536;
        p = longint'(nf) + hf;
        pz = longint'(nz) + hf;
        t = signed_mul_round(p, clat, 30);
        r.ecef_x = 34'(signed_mul_round(t, clon, 46));
        r.ecef_y = 34'(signed_mul_round(t, slon, 46));
        r.ecef_z = 34'(signed_mul_round(pz, slat, 46));
    endtask

    function automatic t_point make_point(longint la, longint lo, longint al);
        t_point pt;
        pt.latitude = 31'(la);
        pt.longitude = 32'(lo);
        pt.altitude = 31'(al);
        return pt;
    endfunction

    function automatic longint rand_span(longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    initial begin
        longint lats[9];
        lats = '{0, LAT_MAX, -LAT_MAX, 377487360, -377487360,
                 1073741823, -1073741824, 754974721, 1};
        foreach (lats[i])
            point_q.push_back(make_point(lats[i], longint'($urandom_range(0, 100)) - 50,
                                         i % 2 ? ALT_MAX : -ALT_MAX));
        point_q.push_back(make_point(0, LON_MAX, 0));
        point_q.push_back(make_point(0, -LON_MAX, 0));
        point_q.push_back(make_point(0, 2147483647, 0));
        point_q.push_back(make_point(0, -2147483648, 0));
        point_q.push_back(make_point(0, LAT_MAX, 0));
        point_q.push_back(make_point(0, -LAT_MAX, 0));
        point_q.push_back(make_point(100, 1000000000, 1073741823));
        point_q.push_back(make_point(-1, -1000000000, -1073741824));
        point_q.push_back(make_point(-1073741824, 2147483647, 1073741823));
        for (int n = 0; n < 600; n++) begin
            case ($urandom_range(0, 9))
                0: point_q.push_back(make_point(longint'($signed(31'($urandom))),
                                                longint'($signed($urandom)),
                                                longint'($signed(31'($urandom)))));
                1: point_q.push_back(make_point(rand_span(LAT_MAX), rand_span(LON_MAX),
                                                rand_span(10000)));
                default: point_q.push_back(make_point(rand_span(LAT_MAX), rand_span(LON_MAX),
                                                      rand_span(ALT_MAX)));
            endcase
        end
        stim_done = 1;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        #2000 no_gaps = 1;
        #4000 no_gaps = 0;
    end

    // driver
    always @(posedge i_clk) begin
        t_ecef r;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                predict_ecef(t_point'(s_tdata[93:0]), r);
                ecef_q.push_back(r);
            end
            if (!s_tvalid || s_tready) begin
                if (point_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 27)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= 96'(point_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_ecef got, want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = t_ecef'(m_tdata[101:0]);
                if (ecef_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item %h", got);
                end else begin
                    want = ecef_q.pop_front();
                    if (got.ecef_x !== want.ecef_x || got.ecef_y !== want.ecef_y ||
                        got.ecef_z !== want.ecef_z) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch x %0d/%0d y %0d/%0d z %0d/%0d",
                                     want.ecef_x, got.ecef_x, want.ecef_y, got.ecef_y,
                                     want.ecef_z, got.ecef_z);
                    end
                end
            end
            if (!hold_done && ecef_q.size() > 20) begin
                hold_count <= hold_count + 1;
                if (hold_count >= HOLD_OFF) hold_done <= 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || $urandom_range(0, 99) >= 27;
            end
        end
    end

    // watchdog and end of run
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end else if (stim_done && point_q.size() == 0 && !s_tvalid && ecef_q.size() == 0
                     && idle_cycles >= 300) begin
            if (mismatches == 0)
                $display("status: pass");
            else
                $display("status: fail");
            $finish;
        end
    end

endmodule
